>>> rtl/rv32ie_pkg.sv
// shared types and constants for the rv32i execute unit
// depends on nothing; used by rv32ie_exec and the top level
package rv32ie_pkg;

	// data memory size in words, a power of two
	localparam int unsigned MEM_WORDS = 65536;
	localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] F7_ALT     = 7'b0100000;
	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

	localparam logic [2:0] F3_B  = 3'd0;
	localparam logic [2:0] F3_H  = 3'd1;
	localparam logic [2:0] F3_W  = 3'd2;

	// everything the execute stage decides for one instruction
	typedef struct packed {
		logic [31:0] npc;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        wr;
		logic        ex;
		logic        unk;
		logic        ld;
		logic [1:0]  ld_size;
		logic [31:0] addr;
		logic        st;
		logic [3:0]  st_be;
		logic [31:0] st_data;
	} exec_t;

endpackage

>>> rtl/rv32i_instruction_execute_unit.sv
// rv32i execute unit top level: register file, data memory, pipeline and handshake
// depends on rv32ie_pkg and rv32ie_exec
// an accepted instruction is registered into execute, then into the result stage
// throughput: one instruction per cycle while out_ready is high; loads finish from
// the registered memory read. reset: registers, pc and halt clear at once; the data
// memory is zeroed by a pass over all MEM_WORDS words, during which no instruction is taken
module rv32i_instruction_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] next_pc,
	output logic [4:0]  rd_index,
	output logic [31:0] rd_value,
	output logic        rd_write,
	output logic        exit_taken,
	output logic        unknown_op
);

	localparam int unsigned AW = rv32ie_pkg::MEM_AW;

	logic [31:0] rf_q [32];
	logic [31:0] mem [rv32ie_pkg::MEM_WORDS];
	logic [31:0] mrd_q;
	logic [31:0] pc_q;
	logic        halted_q;
	logic        clr_q;
	logic [AW-1:0] clr_cnt_q;

	logic        v_s1;
	logic [31:0] instr_s1, a_s1, b_s1;

	logic        v_s2, wr_s2, ex_s2, unk_s2, ld_s2;
	logic [4:0]  rd_s2;
	logic [31:0] npc_s2, val_s2;
	logic [1:0]  size_s2, lane_s2;

	logic        en, in_acc, out_acc, mv;
	logic [31:0] fin_val, ld_val, shw, a_fw, b_fw, x10_fw, rd_a, rd_b;
	logic [AW-1:0] idx;
	rv32ie_pkg::exec_t ex_r;

	assign en       = !v_s2 || out_ready;
	assign in_ready = !clr_q && (!v_s1 || en);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = v_s2 && out_ready;
	assign mv       = v_s1 && en;

	// load result shaping from the registered memory word
	always_comb begin
		shw = mrd_q >> {lane_s2, 3'b000};
		case (size_s2)
			2'd0: ld_val = {{24{shw[7]}}, shw[7:0]};
			2'd1: ld_val = lane_s2[1] ? {{16{mrd_q[31]}}, mrd_q[31:16]}
			                          : {{16{mrd_q[15]}}, mrd_q[15:0]};
			default: ld_val = mrd_q;
		endcase
	end
	assign fin_val = ld_s2 ? ld_val : val_s2;

	// register read with bypass of the write leaving the result stage
	assign rd_a = (out_acc && wr_s2 && rd_s2 == instr[19:15]) ? fin_val : rf_q[instr[19:15]];
	assign rd_b = (out_acc && wr_s2 && rd_s2 == instr[24:20]) ? fin_val : rf_q[instr[24:20]];

	// forward from the result stage into execute
	assign a_fw   = (v_s2 && wr_s2 && rd_s2 == instr_s1[19:15]) ? fin_val : a_s1;
	assign b_fw   = (v_s2 && wr_s2 && rd_s2 == instr_s1[24:20]) ? fin_val : b_s1;
	assign x10_fw = (v_s2 && wr_s2 && rd_s2 == 5'd10) ? fin_val : rf_q[10];

	rv32ie_exec u_exec (
		.instr  (instr_s1),
		.pc     (pc_q),
		.a      (a_fw),
		.b      (b_fw),
		.x10    (x10_fw),
		.halted (halted_q),
		.res    (ex_r)
	);

	assign idx = ex_r.addr[AW+1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			pc_q      <= '0;
			halted_q  <= 1'b0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(rv32ie_pkg::MEM_WORDS - 1)) clr_q <= 1'b0;
			end
			if (in_acc) v_s1 <= 1'b1;
			else if (en) v_s1 <= 1'b0;
			if (en) v_s2 <= v_s1;
			if (mv) begin
				pc_q <= ex_r.npc;
				if (ex_r.ex) halted_q <= 1'b1;
			end
			if (out_acc && wr_s2) rf_q[rd_s2] <= fin_val;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1 <= instr;
			a_s1     <= rd_a;
			b_s1     <= rd_b;
		end
		if (mv) begin
			npc_s2  <= ex_r.npc;
			rd_s2   <= ex_r.rd;
			val_s2  <= ex_r.val;
			wr_s2   <= ex_r.wr;
			ex_s2   <= ex_r.ex;
			unk_s2  <= ex_r.unk;
			ld_s2   <= ex_r.ld;
			size_s2 <= ex_r.ld_size;
			lane_s2 <= ex_r.addr[1:0];
		end
	end

	// data memory: clearing pass, byte-lane store, registered load read
	always_ff @(posedge clk) begin
		if (clr_q) mem[clr_cnt_q] <= '0;
		else if (mv && ex_r.st) begin
			for (int l = 0; l < 4; l++)
				if (ex_r.st_be[l]) mem[idx][8*l +: 8] <= ex_r.st_data[8*l +: 8];
		end
		if (mv && ex_r.ld) mrd_q <= mem[idx];
	end

	assign out_valid  = v_s2;
	assign next_pc    = npc_s2;
	assign rd_index   = rd_s2;
	assign rd_value   = wr_s2 ? fin_val : 32'd0;
	assign rd_write   = wr_s2;
	assign exit_taken = ex_s2;
	assign unknown_op = unk_s2;

endmodule

>>> rtl/rv32ie_exec.sv
// decode, alu, branch and address logic for one rv32i instruction
// depends on rv32ie_pkg
module rv32ie_exec (
	input  logic [31:0]         instr,
	input  logic [31:0]         pc,
	input  logic [31:0]         a,
	input  logic [31:0]         b,
	input  logic [31:0]         x10,
	input  logic                halted,
	output rv32ie_pkg::exec_t   res
);

	function automatic logic [32:0] alu(input logic [2:0] f3, input logic [6:0] f7,
		input logic imm, input logic [31:0] x, input logic [31:0] y);
		logic [4:0]  sh;
		logic [31:0] r;
		logic        ok;
		sh = y[4:0];
		r  = '0;
		ok = 1'b1;
		case (f3)
			3'd0: begin
				if (imm || f7 == 7'd0) r = x + y;
				else if (f7 == rv32ie_pkg::F7_ALT) r = x - y;
				else ok = 1'b0;
			end
			3'd1: begin
				if (f7 != 7'd0) ok = 1'b0;
				else r = x << sh;
			end
			3'd2: begin
				if (!imm && f7 != 7'd0) ok = 1'b0;
				else r = {31'd0, $signed(x) < $signed(y)};
			end
			3'd3: begin
				if (!imm && f7 != 7'd0) ok = 1'b0;
				else r = {31'd0, x < y};
			end
			3'd4: begin
				if (!imm && f7 != 7'd0) ok = 1'b0;
				else r = x ^ y;
			end
			3'd5: begin
				if (f7 == 7'd0) r = x >> sh;
				else if (f7 == rv32ie_pkg::F7_ALT) r = 32'($signed(x) >>> sh);
				else ok = 1'b0;
			end
			3'd6: begin
				if (!imm && f7 != 7'd0) ok = 1'b0;
				else r = x | y;
			end
			default: begin
				if (!imm && f7 != 7'd0) ok = 1'b0;
				else r = x & y;
			end
		endcase
		return {ok, r};
	endfunction

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4, ea;
	logic [32:0] alu_r;
	logic        take;

	assign opc   = instr[6:0];
	assign f3    = instr[14:12];
	assign f7    = instr[31:25];
	assign imm_i = {{20{instr[31]}}, instr[31:20]};
	assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b = {{20{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_j = {{12{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
	assign pc4   = pc + 32'd4;
	assign ea    = a + ((opc == rv32ie_pkg::OPC_STORE) ? imm_s : imm_i);

	always_comb begin
		res       = '0;
		res.npc   = pc4;
		res.rd    = instr[11:7];
		res.addr  = ea;
		alu_r     = '0;
		take      = 1'b0;
		case (opc)
			rv32ie_pkg::OPC_LUI: begin
				res.val = {instr[31:12], 12'd0};
				res.wr  = 1'b1;
			end
			rv32ie_pkg::OPC_AUIPC: begin
				res.val = pc + {instr[31:12], 12'd0};
				res.wr  = 1'b1;
			end
			rv32ie_pkg::OPC_JAL: begin
				res.val = pc4;
				res.wr  = 1'b1;
				res.npc = pc + imm_j;
			end
			rv32ie_pkg::OPC_JALR: begin
				if (f3 != 3'd0) res.unk = 1'b1;
				else begin
					res.val = pc4;
					res.wr  = 1'b1;
					res.npc = (a + imm_i) & ~32'd1;
				end
			end
			rv32ie_pkg::OPC_BRANCH: begin
				case (f3)
					3'd0: take = (a == b);
					3'd1: take = (a != b);
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = (a < b);
					3'd7: take = (a >= b);
					default: res.unk = 1'b1;
				endcase
				if (take) res.npc = pc + imm_b;
			end
			rv32ie_pkg::OPC_LOAD: begin
				if (f3 == rv32ie_pkg::F3_B || f3 == rv32ie_pkg::F3_H ||
				    f3 == rv32ie_pkg::F3_W) begin
					res.wr      = 1'b1;
					res.ld      = 1'b1;
					res.ld_size = f3[1:0];
				end else res.unk = 1'b1;
			end
			rv32ie_pkg::OPC_STORE: begin
				case (f3)
					rv32ie_pkg::F3_B: begin
						res.st      = 1'b1;
						res.st_be   = 4'b0001 << ea[1:0];
						res.st_data = {4{b[7:0]}};
					end
					rv32ie_pkg::F3_H: begin
						res.st      = 1'b1;
						res.st_be   = ea[1] ? 4'b1100 : 4'b0011;
						res.st_data = {2{b[15:0]}};
					end
					rv32ie_pkg::F3_W: begin
						res.st      = 1'b1;
						res.st_be   = 4'b1111;
						res.st_data = b;
					end
					default: res.unk = 1'b1;
				endcase
			end
			rv32ie_pkg::OPC_OPIMM: begin
				if (f3 == 3'd1 || f3 == 3'd5) alu_r = alu(f3, f7, 1'b1, a, {27'd0, instr[24:20]});
				else alu_r = alu(f3, 7'd0, 1'b1, a, imm_i);
				res.val = alu_r[31:0];
				res.wr  = alu_r[32];
				res.unk = !alu_r[32];
			end
			rv32ie_pkg::OPC_OP: begin
				alu_r   = alu(f3, f7, 1'b0, a, b);
				res.val = alu_r[31:0];
				res.wr  = alu_r[32];
				res.unk = !alu_r[32];
			end
			rv32ie_pkg::OPC_SYSTEM: begin
				if (instr != rv32ie_pkg::ECALL_WORD) res.unk = 1'b1;
				else if (x10 == 32'd10) begin
					res.ex  = 1'b1;
					res.npc = pc;
				end
			end
			default: res.unk = 1'b1;
		endcase
		// writes to x0 vanish, and an instruction that does not write reports rd and value as zero
		if (!res.wr || res.rd == 5'd0) begin
			res.wr  = 1'b0;
			res.rd  = 5'd0;
			res.val = '0;
			res.ld  = 1'b0;
		end
		if (halted) begin
			res     = '0;
			res.npc = pc;
			res.ex  = 1'b1;
		end
	end

endmodule

>>> tb/tb_rv32i_instruction_execute_unit.sv
// testbench for the rv32i execute unit: directed rows, random instruction stream, halt tail
// depends on rv32ie_pkg and rv32i_instruction_execute_unit; checks every result beat
// against preset values or an in-bench instruction-set predictor with its own registers, memory and pc
`timescale 1ns / 100ps

module tb_rv32i_instruction_execute_unit;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned N_RANDOM    = 1000;

	typedef struct {
		logic [31:0] npc;
		logic [4:0]  rd;
		logic [31:0] val;
		logic        wr;
		logic        ex;
		logic        unk;
	} retire_t;

	typedef struct {
		logic [31:0] word;
		bit          known;
		retire_t     want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instr;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] next_pc;
	logic [4:0]  rd_index;
	logic [31:0] rd_value;
	logic        rd_write;
	logic        exit_taken;
	logic        unknown_op;

	// architectural state of the predictor
	logic [31:0] arch_x [32];
	logic [31:0] arch_pc;
	logic [31:0] arch_mem [int unsigned];
	bit          arch_halted;

	retire_t     retire_q [$];
	row_t        head_rows [$];
	row_t        tail_rows [$];
	int unsigned err_cnt;
	int unsigned sent_cnt;
	int unsigned cycle_cnt;
	int unsigned hold_cnt;
	bit          hold_done;
	bit          quiet;

	rv32i_instruction_execute_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .instr(instr),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .rd_index(rd_index), .rd_value(rd_value),
		.rd_write(rd_write), .exit_taken(exit_taken), .unknown_op(unknown_op)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// encoders
	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32ie_pkg::OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rv32ie_pkg::OPC_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32ie_pkg::OPC_JAL};
	endfunction

	function automatic logic [31:0] mem_rd(logic [31:0] addr);
		int unsigned idx;
		idx = (addr >> 2) % rv32ie_pkg::MEM_WORDS;
		return arch_mem.exists(idx) ? arch_mem[idx] : 32'h0;
	endfunction

	function automatic bit alu_calc(logic [2:0] f3, logic [6:0] f7, bit is_imm,
			logic [31:0] a, logic [31:0] b, output logic [31:0] res);
		logic [4:0] sh;
		sh = b[4:0];
		res = 32'h0;
		case (f3)
			3'd0: begin
				if (is_imm || f7 == 7'd0) res = a + b;
				else if (f7 == rv32ie_pkg::F7_ALT) res = a - b;
				else return 1'b0;
			end
			3'd1: begin
				if (f7 != 7'd0) return 1'b0;
				res = a << sh;
			end
			3'd5: begin
				if (f7 == 7'd0) res = a >> sh;
				else if (f7 == rv32ie_pkg::F7_ALT) res = $signed(a) >>> sh;
				else return 1'b0;
			end
			default: begin
				if (!is_imm && f7 != 7'd0) return 1'b0;
				case (f3)
					3'd2: res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					3'd3: res = (a < b) ? 32'd1 : 32'd0;
					3'd4: res = a ^ b;
					3'd6: res = a | b;
					default: res = a & b;
				endcase
			end
		endcase
		return 1'b1;
	endfunction

	// executes one instruction on the predictor state and returns its retirement
	function automatic retire_t retire_instr(logic [31:0] w);
		retire_t r;
		logic [6:0]  opc;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, addr, mw, mask;
		logic [4:0]  sh;
		int unsigned idx;
		bit take;
		opc   = w[6:0];
		f3    = w[14:12];
		f7    = w[31:25];
		a     = arch_x[w[19:15]];
		b     = arch_x[w[24:20]];
		imm_i = {{20{w[31]}}, w[31:20]};
		imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
		imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		r = '{npc: arch_pc + 32'd4, rd: w[11:7], val: 32'h0, wr: 1'b0, ex: 1'b0, unk: 1'b0};
		if (arch_halted) begin
			r = '{npc: arch_pc, rd: 5'd0, val: 32'h0, wr: 1'b0, ex: 1'b1, unk: 1'b0};
			return r;
		end
		case (opc)
			rv32ie_pkg::OPC_LUI: begin
				r.val = {w[31:12], 12'h0}; r.wr = 1'b1;
			end
			rv32ie_pkg::OPC_AUIPC: begin
				r.val = arch_pc + {w[31:12], 12'h0}; r.wr = 1'b1;
			end
			rv32ie_pkg::OPC_JAL: begin
				r.val = arch_pc + 32'd4; r.wr = 1'b1; r.npc = arch_pc + imm_j;
			end
			rv32ie_pkg::OPC_JALR: begin
				if (f3 != 3'd0) r.unk = 1'b1;
				else begin
					r.val = arch_pc + 32'd4; r.wr = 1'b1;
					r.npc = (a + imm_i) & ~32'd1;
				end
			end
			rv32ie_pkg::OPC_BRANCH: begin
				take = 1'b0;
				case (f3)
					3'd0: take = (a == b);
					3'd1: take = (a != b);
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = !($signed(a) < $signed(b));
					3'd6: take = (a < b);
					3'd7: take = (a >= b);
					default: r.unk = 1'b1;
				endcase
				if (take) r.npc = arch_pc + imm_b;
			end
			rv32ie_pkg::OPC_LOAD: begin
				addr = a + imm_i;
				mw = mem_rd(addr);
				r.wr = 1'b1;
				case (f3)
					rv32ie_pkg::F3_B: begin
						r.val = (mw >> (8 * addr[1:0])) & 32'hFF;
						r.val = {{24{r.val[7]}}, r.val[7:0]};
					end
					rv32ie_pkg::F3_H: begin
						r.val = (mw >> (16 * addr[1])) & 32'hFFFF;
						r.val = {{16{r.val[15]}}, r.val[15:0]};
					end
					rv32ie_pkg::F3_W: r.val = mw;
					default: begin
						r.unk = 1'b1; r.wr = 1'b0;
					end
				endcase
			end
			rv32ie_pkg::OPC_STORE: begin
				addr = a + imm_s;
				idx = (addr >> 2) % rv32ie_pkg::MEM_WORDS;
				mw = mem_rd(addr);
				case (f3)
					rv32ie_pkg::F3_B: begin
						sh = {addr[1:0], 3'b000};
						mask = 32'hFF << sh;
						arch_mem[idx] = (mw & ~mask) | ((b << sh) & mask);
					end
					rv32ie_pkg::F3_H: begin
						sh = {addr[1], 4'b0000};
						mask = 32'hFFFF << sh;
						arch_mem[idx] = (mw & ~mask) | ((b << sh) & mask);
					end
					rv32ie_pkg::F3_W: arch_mem[idx] = b;
					default: r.unk = 1'b1;
				endcase
			end
			rv32ie_pkg::OPC_OPIMM: begin
				if (f3 == 3'd1 || f3 == 3'd5)
					r.wr = alu_calc(f3, f7, 1'b1, a, {27'd0, w[24:20]}, r.val);
				else
					r.wr = alu_calc(f3, 7'd0, 1'b1, a, imm_i, r.val);
				r.unk = !r.wr;
			end
			rv32ie_pkg::OPC_OP: begin
				r.wr = alu_calc(f3, f7, 1'b0, a, b, r.val);
				r.unk = !r.wr;
			end
			rv32ie_pkg::OPC_SYSTEM: begin
				if (w != rv32ie_pkg::ECALL_WORD) r.unk = 1'b1;
				else if (arch_x[10] == 32'd10) begin
					r.ex = 1'b1; arch_halted = 1'b1; r.npc = arch_pc;
				end
			end
			default: r.unk = 1'b1;
		endcase
		if (!r.wr || r.rd == 5'd0) begin
			r.wr = 1'b0; r.rd = 5'd0; r.val = 32'h0;
		end else arch_x[r.rd] = r.val;
		arch_pc = r.npc;
		return r;
	endfunction

	// random instruction, mostly well formed; never halts the core early
	function automatic logic [31:0] rand_instr();
		logic [4:0]  rd, rs1, rs2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [11:0] imm;
		logic [31:0] w;
		int unsigned pick;
		rd   = 5'($urandom_range(0, 31));
		rs1  = 5'($urandom_range(0, 31));
		rs2  = 5'($urandom_range(0, 31));
		f3   = 3'($urandom_range(0, 7));
		imm  = 12'($urandom);
		pick = $urandom_range(0, 9);
		f7   = (pick < 5) ? 7'd0 : (pick < 9) ? rv32ie_pkg::F7_ALT : 7'($urandom);
		// keep many data accesses in a small window so loads see stored data
		if ($urandom_range(0, 1)) begin
			rs1 = 5'd0;
			imm = 12'($urandom_range(0, 63));
		end
		pick = $urandom_range(0, 99);
		if (pick < 6)
			w = {20'($urandom), rd,
				($urandom_range(0, 1) ? rv32ie_pkg::OPC_LUI : rv32ie_pkg::OPC_AUIPC)};
		else if (pick < 10) w = enc_j(21'($urandom), rd);
		else if (pick < 14)
			w = enc_i(imm, rs1, ($urandom_range(0, 3) ? 3'd0 : f3), rd, rv32ie_pkg::OPC_JALR);
		else if (pick < 26) w = enc_b(13'($urandom), rs2, rs1, f3);
		else if (pick < 41)
			w = enc_i(imm, rs1, ($urandom_range(0, 3) ? 3'($urandom_range(0, 2)) : f3),
				rd, rv32ie_pkg::OPC_LOAD);
		else if (pick < 56)
			w = enc_s(imm, rs2, rs1, ($urandom_range(0, 3) ? 3'($urandom_range(0, 2)) : f3));
		else if (pick < 74) begin
			if (f3 == 3'd1 || f3 == 3'd5) imm = {f7, rs2};
			w = enc_i(imm, rs1, f3, rd, rv32ie_pkg::OPC_OPIMM);
		end else if (pick < 92) w = enc_r(f7, rs2, rs1, f3, rd, rv32ie_pkg::OPC_OP);
		else if (pick < 95) w = rv32ie_pkg::ECALL_WORD;
		else w = $urandom;
		if (w == rv32ie_pkg::ECALL_WORD && arch_x[10] == 32'd10)
			w = enc_i(12'd1, 5'd10, 3'd0, 5'd10, rv32ie_pkg::OPC_OPIMM);
		return w;
	endfunction

	function automatic row_t mk_row(logic [31:0] w);
		row_t r;
		r.word = w;
		r.known = 1'b0;
		r.want = '{npc: 32'h0, rd: 5'd0, val: 32'h0, wr: 1'b0, ex: 1'b0, unk: 1'b0};
		return r;
	endfunction

	function automatic row_t mk_known(logic [31:0] w, logic [31:0] npc, logic [4:0] rd,
			logic [31:0] val, logic wr, logic unk);
		row_t r;
		r.word = w;
		r.known = 1'b1;
		r.want = '{npc: npc, rd: rd, val: val, wr: wr, ex: 1'b0, unk: unk};
		return r;
	endfunction

	// offers one instruction beat and records its retirement once accepted
	task automatic issue(row_t row);
		retire_t r;
		while (!quiet && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		instr <= row.word;
		do @(posedge clk); while (!in_ready);
		r = retire_instr(row.word);
		retire_q.push_back(row.known ? row.want : r);
		sent_cnt++;
	endtask

	// result beats: checking, random stalls and one long hold-off
	always @(posedge clk) begin
		retire_t e;
		if (arst_n && out_valid && out_ready) begin
			if (retire_q.size() == 0) begin
				$error("result beat with nothing expected, next_pc %h", next_pc);
				err_cnt++;
			end else begin
				e = retire_q.pop_front();
				if (next_pc !== e.npc) begin
					$error("next_pc expected %h got %h", e.npc, next_pc); err_cnt++;
				end
				if (rd_index !== e.rd) begin
					$error("rd_index expected %0d got %0d", e.rd, rd_index); err_cnt++;
				end
				if (rd_value !== e.val) begin
					$error("rd_value expected %h got %h", e.val, rd_value); err_cnt++;
				end
				if (rd_write !== e.wr) begin
					$error("rd_write expected %b got %b", e.wr, rd_write); err_cnt++;
				end
				if (exit_taken !== e.ex) begin
					$error("exit_taken expected %b got %b", e.ex, exit_taken); err_cnt++;
				end
				if (unknown_op !== e.unk) begin
					$error("unknown_op expected %b got %b", e.unk, unknown_op); err_cnt++;
				end
			end
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (!hold_done && sent_cnt >= 200) begin
			hold_done = 1'b1;
			hold_cnt = 300;
			out_ready <= 1'b0;
		end else out_ready <= quiet || $urandom_range(0, 99) >= 13;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		quiet <= (sent_cnt >= 450 && sent_cnt < 650);
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		instr = 32'h0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		err_cnt = 0;
		sent_cnt = 0;
		cycle_cnt = 0;
		hold_cnt = 0;
		hold_done = 1'b0;
		quiet = 1'b0;
		arch_pc = 32'h0;
		arch_halted = 1'b0;
		foreach (arch_x[i]) arch_x[i] = 32'h0;

		// rows up to the first jump run at pc 0, 4, 8 ...
		head_rows.push_back(mk_known(32'hFFFFF0B7, 32'd4, 5'd1, 32'hFFFFF000, 1'b1, 1'b0));
		head_rows.push_back(mk_known(32'hFFFFFFFF, 32'd8, 5'd0, 32'h0, 1'b0, 1'b1));
		head_rows.push_back(mk_known(32'h00100073, 32'd12, 5'd0, 32'h0, 1'b0, 1'b1));
		head_rows.push_back(mk_known(enc_i(12'd0, 5'd0, 3'd4, 5'd3, rv32ie_pkg::OPC_LOAD),
			32'd16, 5'd0, 32'h0, 1'b0, 1'b1));
		head_rows.push_back(mk_row(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, rv32ie_pkg::OPC_OPIMM)));
		head_rows.push_back(mk_row(enc_i(12'd5, 5'd1, 3'd0, 5'd0, rv32ie_pkg::OPC_OPIMM)));
		head_rows.push_back(mk_row(rv32ie_pkg::ECALL_WORD));
		head_rows.push_back(mk_row(32'h80000197));
		head_rows.push_back(mk_row(enc_s(12'd0, 5'd2, 5'd0, rv32ie_pkg::F3_W)));
		head_rows.push_back(mk_row(enc_s(12'd7, 5'd3, 5'd0, rv32ie_pkg::F3_B)));
		head_rows.push_back(mk_row(enc_s(12'd10, 5'd3, 5'd0, rv32ie_pkg::F3_H)));
		head_rows.push_back(mk_row(enc_i(12'd7, 5'd0, rv32ie_pkg::F3_B, 5'd4,
			rv32ie_pkg::OPC_LOAD)));
		head_rows.push_back(mk_row(enc_i(12'd11, 5'd0, rv32ie_pkg::F3_H, 5'd5,
			rv32ie_pkg::OPC_LOAD)));
		head_rows.push_back(mk_row(enc_i(12'd3, 5'd0, rv32ie_pkg::F3_W, 5'd6,
			rv32ie_pkg::OPC_LOAD)));
		// wraps to the top word, never written
		head_rows.push_back(mk_row(enc_i(12'hFFC, 5'd0, rv32ie_pkg::F3_W, 5'd7,
			rv32ie_pkg::OPC_LOAD)));
		head_rows.push_back(mk_row(enc_i(12'hFFF, 5'd0, 3'd3, 5'd8, rv32ie_pkg::OPC_OPIMM)));
		head_rows.push_back(mk_row(enc_i({rv32ie_pkg::F7_ALT, 5'd31}, 5'd1, 3'd5, 5'd9,
			rv32ie_pkg::OPC_OPIMM)));
		head_rows.push_back(mk_row(enc_r(rv32ie_pkg::F7_ALT, 5'd1, 5'd0, 3'd0, 5'd11,
			rv32ie_pkg::OPC_OP)));
		head_rows.push_back(mk_row(enc_r(rv32ie_pkg::F7_ALT, 5'd6, 5'd1, 3'd5, 5'd12,
			rv32ie_pkg::OPC_OP)));
		head_rows.push_back(mk_row(enc_r(7'd0, 5'd0, 5'd1, 3'd2, 5'd13, rv32ie_pkg::OPC_OP)));
		head_rows.push_back(mk_row(enc_r(7'h01, 5'd2, 5'd1, 3'd0, 5'd13, rv32ie_pkg::OPC_OP)));
		head_rows.push_back(mk_row(enc_b(13'd8, 5'd2, 5'd0, 3'd6)));
		head_rows.push_back(mk_row(enc_b(13'd8, 5'd2, 5'd0, 3'd2)));
		head_rows.push_back(mk_row(enc_j(-21'sd16, 5'd14)));
		// odd target has bit 0 cleared
		head_rows.push_back(mk_row(enc_i(12'd4, 5'd2, 3'd0, 5'd15, rv32ie_pkg::OPC_JALR)));

		tail_rows.push_back(mk_row(enc_i(12'd10, 5'd0, 3'd0, 5'd10, rv32ie_pkg::OPC_OPIMM)));
		tail_rows.push_back(mk_row(rv32ie_pkg::ECALL_WORD));
		tail_rows.push_back(mk_row(enc_i(12'd1, 5'd0, 3'd0, 5'd1, rv32ie_pkg::OPC_OPIMM)));
		tail_rows.push_back(mk_row(32'hFFFFFFFF));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (head_rows[i]) issue(head_rows[i]);
		repeat (N_RANDOM) issue(mk_row(rand_instr()));
		foreach (tail_rows[i]) issue(tail_rows[i]);
		in_valid <= 1'b0;

		while (retire_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
